// ===== src/mvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

  // item codes on the input channel
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_MIX   = 2'd2;

  localparam logic [15:0] MASTER_RESET = 16'h8000;  // unity in Q1.15
  localparam logic [16:0] MAX_FRAMES   = 17'h10000;

  localparam int PROD_W   = 50;
  localparam int SCALED_W = 20;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] frames;
    logic [16:0] pos;
    logic [15:0] gain;
  } voice_t;

  // product of two q1.15 gains and a sample, shifted down by 30, toward zero
  function automatic logic signed [SCALED_W-1:0] scale_trunc(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] t;
    bias = p[PROD_W-1] ? PROD_W'(50'h3FFF_FFFF) : '0;
    t    = p + bias;
    return $signed(t[PROD_W-1:30]);
  endfunction

endpackage

`default_nettype wire

// ===== src/mvm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mvm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [15:0]        sample_address;
  logic signed [15:0] sample_left;
  logic signed [15:0] sample_right;
  logic [15:0]        voice_start;
  logic [16:0]        voice_length;
  logic [15:0]        voice_volume;
  logic signed [15:0] dry_left;
  logic signed [15:0] dry_right;

  modport source (
    output valid, mode, sample_address, sample_left, sample_right,
           voice_start, voice_length, voice_volume, dry_left, dry_right,
    input  ready
  );
  modport sink (
    input  valid, mode, sample_address, sample_left, sample_right,
           voice_start, voice_length, voice_volume, dry_left, dry_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mvm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_left;
  logic signed [15:0] mixed_right;
  logic               clipped;
  logic [3:0]         active_voices;
  logic               start_accepted;

  modport source (
    output valid, mixed_left, mixed_right, clipped, active_voices, start_accepted,
    input  ready
  );
  modport sink (
    input  valid, mixed_left, mixed_right, clipped, active_voices, start_accepted,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mvm_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared signed x unsigned multiplier with a registered product
module mvm_mul (
  input  wire                                  clk_i,
  input  wire logic signed [16:0]              a_i,
  input  wire logic [31:0]                     b_i,
  output logic signed [mvm_pkg::PROD_W-1:0]    p_o
);

  logic signed [mvm_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * $signed({1'b0, b_i});
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== src/mvm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// stereo frame store, one write and one registered read port
module mvm_store #(
  parameter int DEPTH = 65536,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AW-1:0]     waddr_i,
  input  wire [31:0]       wdata_i,
  input  wire              re_i,
  input  wire [AW-1:0]     raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/mvm_vtab.sv =====
`timescale 1ns / 1ps
`default_nettype none

// voice slot table: base, length, head and gain of each slot
module mvm_vtab #(
  parameter int SLOTS = 8,
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire [SW-1:0]           waddr_i,
  input  wire mvm_pkg::voice_t   wdata_i,
  input  wire [SW-1:0]           raddr_i,
  output mvm_pkg::voice_t        rdata_o
);

  mvm_pkg::voice_t tab_q [SLOTS];
  mvm_pkg::voice_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tab_q[waddr_i] <= wdata_i;
    end
    rdata_q <= tab_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/multi_voice_sample_mixer_core.sv =====
// Stereo multi-voice sample mixer.
// Input channel in_i carries one word per item: mode selects load frame,
// start voice or mix one output frame. Output channel out_o carries one
// word per start or mix item; loads and the unused mode give no word.
// master_volume_we_i/master_volume_i write the master gain (reset 1.0);
// the user must write it only while the block is idle (not enforced).
// A load is stored as it is taken; a start goes to the finish state. A
// mix walks the slots with one shared multiplier: a free slot takes the
// read state, a voice that ends with nothing to play takes read and
// check, a playing voice read, check, left, right and accumulate, then
// the finish state ends the item. Items are taken one at a time;
// in_i.ready is low while a start or mix is busy. The result register
// lets a new item enter while out_o holds a word; if out_o stalls, the
// next start or mix finishes its work and then waits for it to empty.
// Reset frees all voice slots and sets master gain to unity; the frame
// store is not cleared and must be loaded before voices play it.
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_sample_mixer_core #(
  parameter int VOICE_SLOTS  = 8,
  parameter int STORE_FRAMES = 65536
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         master_volume_we_i,
  input  wire [15:0]  master_volume_i,
  mvm_in_if.sink      in_i,
  mvm_out_if.source   out_o
);

  localparam int MEM_DEPTH = (STORE_FRAMES < 65536) ? STORE_FRAMES : 65536;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SW        = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W     = $clog2(VOICE_SLOTS + 1);
  localparam int ACC_W     = 21 + $clog2(VOICE_SLOTS + 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MIX_RD  = 3'd1;
  localparam logic [2:0] ST_MIX_CHK = 3'd2;
  localparam logic [2:0] ST_MIX_L   = 3'd3;
  localparam logic [2:0] ST_MIX_R   = 3'd4;
  localparam logic [2:0] ST_MIX_ACC = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  // frame address modulo store size by compare and subtract, for addresses below 256 x store size
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [31:0] v;
    v = {16'b0, a};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (32'(STORE_FRAMES) << k)) begin
        v = v - (32'(STORE_FRAMES) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [2:0]              state_q;
  logic [VOICE_SLOTS-1:0]  active_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [15:0]             master_q;
  logic [SW-1:0]           slot_q;
  logic                    out_valid_q;

  logic signed [ACC_W-1:0] acc_l_q;
  logic signed [ACC_W-1:0] acc_r_q;
  logic [31:0]             gm_q;
  logic                    flag_q;
  logic signed [15:0]      out_l_q;
  logic signed [15:0]      out_r_q;
  logic                    out_clip_q;
  logic [3:0]              out_cnt_q;
  logic                    out_acc_q;

  logic                    in_acc;
  logic                    free_found;
  logic [SW-1:0]           free_idx;
  logic [16:0]             len_sat;
  logic                    last_slot;
  logic                    out_free;

  mvm_pkg::voice_t         vt_rd;
  mvm_pkg::voice_t         vt_wdata;
  logic                    vt_we;
  logic [SW-1:0]           vt_waddr;
  logic                    playing;
  logic [16:0]             pos_inc;
  logic                    ends_now;

  logic                    st_we;
  logic                    st_re;
  logic [AW-1:0]           st_waddr;
  logic [AW-1:0]           st_raddr;
  logic [31:0]             st_rd;

  logic signed [16:0]                    mul_a;
  logic [31:0]                           mul_b;
  logic signed [mvm_pkg::PROD_W-1:0]     prod;
  logic signed [mvm_pkg::SCALED_W-1:0]   scaled;

  logic signed [15:0]      sat_l;
  logic signed [15:0]      sat_r;
  logic                    clip;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign last_slot  = (slot_q == SW'(VOICE_SLOTS - 1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign len_sat    = in_i.voice_length[16] ? mvm_pkg::MAX_FRAMES : in_i.voice_length;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign playing  = (vt_rd.pos < vt_rd.frames);
  assign pos_inc  = vt_rd.pos + 17'd1;
  assign ends_now = !playing || (pos_inc >= vt_rd.frames);

  always_comb begin
    if (state_q == ST_IDLE) begin
      vt_we           = in_acc && (in_i.mode == mvm_pkg::MODE_START) && free_found;
      vt_waddr        = free_idx;
      vt_wdata.base   = in_i.voice_start;
      vt_wdata.frames = len_sat;
      vt_wdata.pos    = '0;
      vt_wdata.gain   = in_i.voice_volume;
    end else begin
      vt_we           = (state_q == ST_MIX_CHK) && playing;
      vt_waddr        = slot_q;
      vt_wdata        = vt_rd;
      vt_wdata.pos    = pos_inc;
    end
  end

  mvm_vtab #(
    .SLOTS (VOICE_SLOTS)
  ) u_vtab (
    .clk_i   (clk_i),
    .we_i    (vt_we),
    .waddr_i (vt_waddr),
    .wdata_i (vt_wdata),
    .raddr_i (slot_q),
    .rdata_o (vt_rd)
  );

  assign st_we    = in_acc && (in_i.mode == mvm_pkg::MODE_LOAD);
  assign st_waddr = wrap_addr(in_i.sample_address);
  assign st_re    = (state_q == ST_MIX_CHK) && playing;
  assign st_raddr = wrap_addr(16'(vt_rd.base + vt_rd.pos[15:0]));

  mvm_store #(
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i ({in_i.sample_right, in_i.sample_left}),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rd)
  );

  // one multiplier: voice gain x master, then left and right x combined gain
  always_comb begin
    case (state_q)
      ST_MIX_CHK: begin
        mul_a = {1'b0, vt_rd.gain};
        mul_b = {16'b0, master_q};
      end
      ST_MIX_L: begin
        mul_a = {st_rd[15], st_rd[15:0]};
        mul_b = prod[31:0];
      end
      ST_MIX_R: begin
        mul_a = {st_rd[31], st_rd[31:16]};
        mul_b = gm_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mvm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign scaled = mvm_pkg::scale_trunc(prod);

  always_comb begin
    clip = 1'b0;
    if (acc_l_q > SAT_HI) begin
      sat_l = 16'sh7FFF;
      clip  = 1'b1;
    end else if (acc_l_q < SAT_LO) begin
      sat_l = -16'sh8000;
      clip  = 1'b1;
    end else begin
      sat_l = acc_l_q[15:0];
    end
    if (acc_r_q > SAT_HI) begin
      sat_r = 16'sh7FFF;
      clip  = 1'b1;
    end else if (acc_r_q < SAT_LO) begin
      sat_r = -16'sh8000;
      clip  = 1'b1;
    end else begin
      sat_r = acc_r_q[15:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      cnt_q       <= '0;
      master_q    <= mvm_pkg::MASTER_RESET;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (master_volume_we_i) begin
        master_q <= master_volume_i;
      end
      // a finished item fills the output register, else a taken word leaves
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.mode == mvm_pkg::MODE_START) begin
              if (free_found) begin
                active_q[free_idx] <= 1'b1;
                cnt_q              <= cnt_q + CNT_W'(1);
              end
              state_q <= ST_FIN;
            end else if (in_i.mode == mvm_pkg::MODE_MIX) begin
              slot_q  <= '0;
              state_q <= ST_MIX_RD;
            end
          end
        end
        ST_MIX_RD: begin
          if (active_q[slot_q]) begin
            state_q <= ST_MIX_CHK;
          end else if (last_slot) begin
            state_q <= ST_FIN;
          end else begin
            slot_q <= slot_q + SW'(1);
          end
        end
        ST_MIX_CHK: begin
          if (ends_now) begin
            active_q[slot_q] <= 1'b0;
            cnt_q            <= cnt_q - CNT_W'(1);
          end
          if (playing) begin
            state_q <= ST_MIX_L;
          end else if (last_slot) begin
            state_q <= ST_FIN;
          end else begin
            slot_q  <= slot_q + SW'(1);
            state_q <= ST_MIX_RD;
          end
        end
        ST_MIX_L: begin
          state_q <= ST_MIX_R;
        end
        ST_MIX_R: begin
          state_q <= ST_MIX_ACC;
        end
        ST_MIX_ACC: begin
          if (last_slot) begin
            state_q <= ST_FIN;
          end else begin
            slot_q  <= slot_q + SW'(1);
            state_q <= ST_MIX_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.mode == mvm_pkg::MODE_MIX) begin
          acc_l_q <= ACC_W'(in_i.dry_left);
          acc_r_q <= ACC_W'(in_i.dry_right);
          flag_q  <= 1'b0;
        end else begin
          // a start word carries zero mix and no clip
          acc_l_q <= '0;
          acc_r_q <= '0;
          flag_q  <= free_found;
        end
      end
      ST_MIX_L: begin
        gm_q <= prod[31:0];
      end
      ST_MIX_R: begin
        acc_l_q <= acc_l_q + ACC_W'(scaled);
      end
      ST_MIX_ACC: begin
        acc_r_q <= acc_r_q + ACC_W'(scaled);
      end
      ST_FIN: begin
        if (out_free) begin
          out_l_q    <= sat_l;
          out_r_q    <= sat_r;
          out_clip_q <= clip;
          out_cnt_q  <= 4'(cnt_q);
          out_acc_q  <= flag_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mixed_left     = out_l_q;
  assign out_o.mixed_right    = out_r_q;
  assign out_o.clipped        = out_clip_q;
  assign out_o.active_voices  = out_cnt_q;
  assign out_o.start_accepted = out_acc_q;

endmodule

`default_nettype wire

// ===== src/mvm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvm_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid,
  input wire               in_ready,
  input wire [1:0]         in_mode,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] mixed_left,
  input wire signed [15:0] mixed_right,
  input wire               clipped,
  input wire               start_accepted
);

  // a word on the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a mix keeps the input busy once it is taken
  a_mix_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == mvm_pkg::MODE_MIX) |=> !in_ready)
    else $error("input taken during a mix");

  // a load completes in the cycle it is taken
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == mvm_pkg::MODE_LOAD) |=> in_ready)
    else $error("load stalled the input");

  // a claimed slot comes from a start word, which has no mix content
  a_start_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && start_accepted |-> !clipped && (mixed_left == 16'sd0) &&
      (mixed_right == 16'sd0))
    else $error("start word carries mix data");

  // clip only with a rail value on some channel
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && clipped |-> (mixed_left == 16'sh7FFF) || (mixed_left == -16'sh8000) ||
      (mixed_right == 16'sh7FFF) || (mixed_right == -16'sh8000))
    else $error("clip without saturated output");

endmodule

bind multi_voice_sample_mixer_core mvm_checker u_mvm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .in_mode        (in_i.mode),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .mixed_left     (out_o.mixed_left),
  .mixed_right    (out_o.mixed_right),
  .clipped        (out_o.clipped),
  .start_accepted (out_o.start_accepted)
);

`default_nettype wire
